FILE: rtl/core/ffra_pkg.sv
// Shared types and constants of the first-fit region allocator.
// Depends on nothing; the top level and the testbench refer to it by scoped names.
package ffra_pkg;

  localparam int DESCRIPTORS_DEF = 8;
  localparam int OFFSET_BITS_DEF = 32;
  localparam logic [31:0] POOL_RESET = 32'h0001_0000;

  localparam logic [1:0] KIND_SPARE = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_USED  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOSPARE  = 2'd2;
  localparam logic [1:0] ST_NOTALLOC = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_size;
    logic [31:0] block_offset;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_offset;
  } out_rsp_t;

endpackage

FILE: rtl/core/ffra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/first_fit_region_allocator_top.sv
// First-fit region allocator: top level with sequencer and descriptor memory.
// Depends on ffra_pkg and ffra_ram.
// An allocate runs a scan, then a rewrite sweep; a free runs a scan, a neighbor lookup
// and a rewrite sweep. Failing requests end after the first scan. One request at a
// time; the next request is accepted in the strobe cycle, so requests never overlap.
// The receiver cannot stall. Reset and a pool_size write run a clearing pass over
// every descriptor with busy high.
module first_fit_region_allocator_top #(
  parameter int DESCRIPTORS = ffra_pkg::DESCRIPTORS_DEF,
  parameter int OFFSET_BITS = ffra_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ffra_pkg::in_req_t in_req,
  output logic              out_valid,
  output ffra_pkg::out_rsp_t out_rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  localparam int AW = $clog2(DESCRIPTORS);
  localparam int CW = $clog2(DESCRIPTORS + 1);
  localparam int OB = OFFSET_BITS;
  localparam int EW = 2 * OB + 2 + AW;
  localparam logic [AW-1:0] LAST = AW'(DESCRIPTORS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN1 = 3'd2;
  localparam logic [2:0] S_SCAN2 = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  // sequencer
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          iss_r, iss_nxt;
  logic          rv_r, rv_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;
  logic [31:0]   pool_r, pool_nxt;
  logic [CW-1:0] un_r, un_nxt, an_r, an_nxt;
  logic          out_valid_r, out_valid_nxt;
  ffra_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;

  // captured request
  logic          op_r, op_nxt;
  logic [OB-1:0] size_r, size_nxt, addr_r, addr_nxt;

  // scan results: allocation candidate, spare, freed region, next and previous free region
  logic          cf_r, cf_nxt, sf_r, sf_nxt, mf_r, mf_nxt, nf_r, nf_nxt;
  logic [AW-1:0] cidx_r, cidx_nxt, crank_r, crank_nxt, sidx_r, sidx_nxt;
  logic [AW-1:0] midx_r, midx_nxt, mrank_r, mrank_nxt;
  logic [AW-1:0] nidx_r, nidx_nxt, nrank_r, nrank_nxt, pidx_r, pidx_nxt;
  logic [OB-1:0] cstart_r, cstart_nxt, clen_r, clen_nxt, mlen_r, mlen_nxt;
  logic [OB-1:0] nstart_r, nstart_nxt, nlen_r, nlen_nxt, pstart_r, pstart_nxt;
  logic [OB-1:0] plen_r, plen_nxt;

  // memory port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  // fields of the entry being read
  logic [OB-1:0] rs, rl;
  logic [1:0]    rk;
  logic [AW-1:0] rr;

  // merge decisions on a free
  logic [CW-1:0] p_pos;
  logic          mg_a, mg_b, exact;

  assign rs = rdata[EW-1 -: OB];
  assign rl = rdata[EW-OB-1 -: OB];
  assign rk = rdata[AW+1 : AW];
  assign rr = rdata[AW-1 : 0];

  // insertion position in the free list: rank of the first free region above the offset
  assign p_pos = nf_r ? CW'(nrank_r) : un_r;
  assign mg_a  = (p_pos != '0) && (OB'(pstart_r + plen_r) == addr_r);
  assign mg_b  = nf_r && (OB'(addr_r + mlen_r) == nstart_r);
  assign exact = (size_r == clen_r);

  assign busy      = (state_r != S_IDLE);
  // take a pool size write only when idle and no request is being accepted
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  ffra_ram #(.WIDTH(EW), .DEPTH(DESCRIPTORS)) u_desc_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    logic [OB-1:0] ns, nl;
    logic [1:0]    nk;
    logic [AW-1:0] nr;
    logic          fin;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    rv_nxt        = 1'b0;
    ridx_nxt      = ridx_r;
    pool_nxt      = pool_r;
    un_nxt        = un_r;
    an_nxt        = an_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    op_nxt        = op_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    cf_nxt = cf_r;  cidx_nxt = cidx_r;  crank_nxt = crank_r;
    cstart_nxt = cstart_r;  clen_nxt = clen_r;
    sf_nxt = sf_r;  sidx_nxt = sidx_r;
    mf_nxt = mf_r;  midx_nxt = midx_r;  mrank_nxt = mrank_r;  mlen_nxt = mlen_r;
    nf_nxt = nf_r;  nidx_nxt = nidx_r;  nrank_nxt = nrank_r;
    nstart_nxt = nstart_r;  nlen_nxt = nlen_r;
    pidx_nxt = pidx_r;  pstart_nxt = pstart_r;  plen_nxt = plen_r;
    we    = 1'b0;
    waddr = ridx_r;
    wdata = rdata;
    raddr = cnt_r;
    ns = rs;  nl = rl;  nk = rk;  nr = rr;
    fin = rv_r && (ridx_r == LAST);

    // read issue for the sweep phases: one entry a cycle, data arrives next cycle
    if ((state_r == S_SCAN1 || state_r == S_SCAN2 || state_r == S_APPLY) && iss_r) begin
      rv_nxt   = 1'b1;
      ridx_nxt = cnt_r;
      if (cnt_r == LAST) begin
        iss_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        // restart the pool: entry zero holds everything, the rest go spare
        we    = 1'b1;
        waddr = cnt_r;
        wdata = (cnt_r == '0) ? {{OB{1'b0}}, OB'(pool_r), ffra_pkg::KIND_FREE, {AW{1'b0}}}
                              : {EW{1'b0}};
        un_nxt = CW'(1);
        an_nxt = '0;
        if (cnt_r == LAST) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_nxt    = in_req.opcode;
          size_nxt  = OB'(in_req.request_size);
          addr_nxt  = OB'(in_req.block_offset);
          cf_nxt = 1'b0;  sf_nxt = 1'b0;  mf_nxt = 1'b0;  nf_nxt = 1'b0;
          cnt_nxt   = '0;
          iss_nxt   = 1'b1;
          state_nxt = S_SCAN1;
        end
      end

      S_SCAN1: begin
        if (rv_r) begin
          if (op_r == ffra_pkg::OP_ALLOC) begin
            // first fitting free region in list order, lowest-numbered spare
            if (rk == ffra_pkg::KIND_FREE && rl >= size_r && (!cf_r || rr < crank_r)) begin
              cf_nxt = 1'b1;  cidx_nxt = ridx_r;  crank_nxt = rr;
              cstart_nxt = rs;  clen_nxt = rl;
            end
            if (rk == ffra_pkg::KIND_SPARE && !sf_r) begin
              sf_nxt = 1'b1;  sidx_nxt = ridx_r;
            end
          end else begin
            // oldest allocated region at the offset, first free region above it
            if (rk == ffra_pkg::KIND_USED && rs == addr_r && (!mf_r || rr < mrank_r)) begin
              mf_nxt = 1'b1;  midx_nxt = ridx_r;  mrank_nxt = rr;  mlen_nxt = rl;
            end
            if (rk == ffra_pkg::KIND_FREE && addr_r < rs && (!nf_r || rr < nrank_r)) begin
              nf_nxt = 1'b1;  nidx_nxt = ridx_r;  nrank_nxt = rr;
              nstart_nxt = rs;  nlen_nxt = rl;
            end
          end
        end
        if (fin) begin
          cnt_nxt = '0;
          iss_nxt = 1'b1;
          out_rsp_nxt.granted_offset = '0;
          if (op_r == ffra_pkg::OP_ALLOC) begin
            if (!cf_nxt) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt.status = ffra_pkg::ST_NOFIT;
              state_nxt = S_IDLE;
            end else if (size_r != clen_nxt && !sf_nxt) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt.status = ffra_pkg::ST_NOSPARE;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_APPLY;
            end
          end else if (!mf_nxt) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt.status = ffra_pkg::ST_NOTALLOC;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SCAN2;
          end
        end
      end

      S_SCAN2: begin
        // fetch the free region just ahead of the insertion position
        if (rv_r && rk == ffra_pkg::KIND_FREE && p_pos != '0 && CW'(rr) == p_pos - 1'b1) begin
          pidx_nxt = ridx_r;  pstart_nxt = rs;  plen_nxt = rl;
        end
        if (fin) begin
          cnt_nxt   = '0;
          iss_nxt   = 1'b1;
          state_nxt = S_APPLY;
        end
      end

      S_APPLY: begin
        // rewrite every entry once with its new start, length, kind and rank
        if (rv_r) begin
          we = 1'b1;
          if (op_r == ffra_pkg::OP_ALLOC) begin
            if (exact) begin
              if (ridx_r == cidx_r) begin
                nk = ffra_pkg::KIND_USED;  nr = AW'(an_r);
              end else if (rk == ffra_pkg::KIND_FREE && rr > crank_r) begin
                nr = rr - 1'b1;
              end
            end else if (ridx_r == sidx_r) begin
              nk = ffra_pkg::KIND_USED;  nr = AW'(an_r);
              ns = cstart_r;  nl = size_r;
            end else if (ridx_r == cidx_r) begin
              ns = cstart_r + size_r;  nl = clen_r - size_r;
            end
          end else begin
            if (ridx_r == midx_r) begin
              if (mg_a || mg_b) begin
                ns = '0;  nl = '0;  nk = ffra_pkg::KIND_SPARE;  nr = '0;
              end else begin
                nk = ffra_pkg::KIND_FREE;  nr = AW'(p_pos);
              end
            end else if (mg_a && mg_b && ridx_r == nidx_r) begin
              ns = '0;  nl = '0;  nk = ffra_pkg::KIND_SPARE;  nr = '0;
            end else if (mg_a && ridx_r == pidx_r) begin
              nl = mg_b ? OB'(plen_r + mlen_r + nlen_r) : OB'(plen_r + mlen_r);
            end else if (mg_b && ridx_r == nidx_r) begin
              ns = addr_r;  nl = nlen_r + mlen_r;
            end else if (rk == ffra_pkg::KIND_USED && rr > mrank_r) begin
              nr = rr - 1'b1;
            end else if (rk == ffra_pkg::KIND_FREE) begin
              if (mg_a && mg_b && CW'(rr) > p_pos) begin
                nr = rr - 1'b1;
              end else if (!mg_a && !mg_b && CW'(rr) >= p_pos) begin
                nr = rr + 1'b1;
              end
            end
          end
          wdata = {ns, nl, nk, nr};
        end
        if (fin) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt.status = ffra_pkg::ST_OK;
          state_nxt = S_IDLE;
          if (op_r == ffra_pkg::OP_ALLOC) begin
            out_rsp_nxt.granted_offset = 32'(cstart_r);
            an_nxt = an_r + 1'b1;
            if (exact) begin
              un_nxt = un_r - 1'b1;
            end
          end else begin
            out_rsp_nxt.granted_offset = '0;
            an_nxt = an_r - 1'b1;
            if (mg_a && mg_b) begin
              un_nxt = un_r - 1'b1;
            end else if (!mg_a && !mg_b) begin
              un_nxt = un_r + 1'b1;
            end
          end
        end
      end

      default: begin
        state_nxt = S_CLEAR;
        cnt_nxt   = '0;
      end
    endcase

    // a pool size write restarts the pool
    if (cfg_valid && cfg_ready) begin
      pool_nxt  = cfg_data;
      state_nxt = S_CLEAR;
      cnt_nxt   = '0;
      iss_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      iss_r       <= 1'b0;
      rv_r        <= 1'b0;
      pool_r      <= ffra_pkg::POOL_RESET;
      un_r        <= CW'(1);
      an_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      rv_r        <= rv_nxt;
      pool_r      <= pool_nxt;
      un_r        <= un_nxt;
      an_r        <= an_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan capture: no reset needed
  always_ff @(posedge clk) begin
    ridx_r    <= ridx_nxt;
    out_rsp_r <= out_rsp_nxt;
    op_r      <= op_nxt;
    size_r    <= size_nxt;
    addr_r    <= addr_nxt;
    cf_r <= cf_nxt;  cidx_r <= cidx_nxt;  crank_r <= crank_nxt;
    cstart_r <= cstart_nxt;  clen_r <= clen_nxt;
    sf_r <= sf_nxt;  sidx_r <= sidx_nxt;
    mf_r <= mf_nxt;  midx_r <= midx_nxt;  mrank_r <= mrank_nxt;  mlen_r <= mlen_nxt;
    nf_r <= nf_nxt;  nidx_r <= nidx_nxt;  nrank_r <= nrank_nxt;
    nstart_r <= nstart_nxt;  nlen_r <= nlen_nxt;
    pidx_r <= pidx_nxt;  pstart_r <= pstart_nxt;  plen_r <= plen_nxt;
  end

`ifndef NO_ASSERTIONS
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != S_IDLE))
    else $error("result strobe without a request in progress");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, un_r} + {1'b0, an_r}) <= (CW + 1)'(DESCRIPTORS))
    else $error("region counts exceed descriptor count");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLEAR || state_r == S_APPLY))
    else $error("descriptor write outside clear or rewrite sweep");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
`endif

endmodule

FILE: bench/tb_first_fit_region_allocator_top.sv
// Testbench for the first-fit region allocator: drives alloc/free requests and
// pool_size writes, predicts each response with a behavioral pool model.
// Depends on ffra_pkg and first_fit_region_allocator_top.
module tb_first_fit_region_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ND = 8;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ffra_pkg::in_req_t in_req = '0;
  logic out_valid;
  ffra_pkg::out_rsp_t out_rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  // Model copy of the descriptor table.
  logic [31:0] pool_bytes;
  logic [31:0] rg_start [ND];
  logic [31:0] rg_len [ND];
  logic [1:0] rg_kind [ND];
  int unsigned rg_rank [ND];

  ffra_pkg::out_rsp_t pending_rsp [$];
  int errors = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;

  first_fit_region_allocator_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Bound the run; report and quit on overrun.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Check every response strobe against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response", {30'd0, out_rsp.status}, 0);
      end else begin
        ffra_pkg::out_rsp_t want;
        want = pending_rsp.pop_front();
        if (out_rsp.status !== want.status)
          report_mismatch("status", {30'd0, out_rsp.status}, {30'd0, want.status});
        if (out_rsp.granted_offset !== want.granted_offset)
          report_mismatch("granted_offset", out_rsp.granted_offset, want.granted_offset);
      end
    end
  end

  function automatic void pool_restart();
    for (int i = 0; i < ND; i++) begin
      rg_kind[i] = ffra_pkg::KIND_SPARE;
      rg_start[i] = '0;
      rg_len[i] = '0;
      rg_rank[i] = 0;
    end
    rg_kind[0] = ffra_pkg::KIND_FREE;
    rg_len[0] = pool_bytes;
  endfunction

  // List the descriptors of one kind in rank order.
  function automatic int list_of(input logic [1:0] kind, output int ord [ND]);
    int n;
    n = 0;
    for (int r = 0; r < ND; r++)
      for (int i = 0; i < ND; i++)
        if (rg_kind[i] == kind && rg_rank[i] == r) begin
          ord[n] = i;
          n++;
        end
    return n;
  endfunction

  function automatic void make_spare(input int i);
    rg_kind[i] = ffra_pkg::KIND_SPARE;
    rg_start[i] = '0;
    rg_len[i] = '0;
    rg_rank[i] = 0;
  endfunction

  function automatic ffra_pkg::out_rsp_t predict_alloc(input logic [31:0] size);
    int uo [ND];
    int ao [ND];
    int un, an, i, s;
    ffra_pkg::out_rsp_t r;
    r = '{status: ffra_pkg::ST_NOFIT, granted_offset: '0};
    un = list_of(ffra_pkg::KIND_FREE, uo);
    an = list_of(ffra_pkg::KIND_USED, ao);
    for (int k = 0; k < un; k++) begin
      i = uo[k];
      if (size == rg_len[i]) begin
        // Exact fit: move whole region to the allocated list.
        for (int j = k; j + 1 < un; j++) uo[j] = uo[j + 1];
        un--;
        rg_kind[i] = ffra_pkg::KIND_USED;
        for (int j = 0; j < un; j++) rg_rank[uo[j]] = j;
        rg_rank[i] = an;
        return '{status: ffra_pkg::ST_OK, granted_offset: rg_start[i]};
      end
      if (size < rg_len[i]) begin
        s = ND;
        for (int j = ND - 1; j >= 0; j--) if (rg_kind[j] == ffra_pkg::KIND_SPARE) s = j;
        if (s == ND) return '{status: ffra_pkg::ST_NOSPARE, granted_offset: '0};
        // Split the front off into the lowest spare descriptor.
        rg_kind[s] = ffra_pkg::KIND_USED;
        rg_start[s] = rg_start[i];
        rg_len[s] = size;
        rg_rank[s] = an;
        rg_start[i] = rg_start[i] + size;
        rg_len[i] = rg_len[i] - size;
        return '{status: ffra_pkg::ST_OK, granted_offset: rg_start[s]};
      end
    end
    return r;
  endfunction

  function automatic ffra_pkg::out_rsp_t predict_free(input logic [31:0] addr);
    int uo [ND];
    int ao [ND];
    int un, an, k, m, p, pr, nx;
    logic [31:0] size, fin;
    bit a, b;
    un = list_of(ffra_pkg::KIND_FREE, uo);
    an = list_of(ffra_pkg::KIND_USED, ao);
    m = -1;
    for (k = 0; k < an; k++)
      if (rg_start[ao[k]] == addr) begin
        m = ao[k];
        break;
      end
    if (m < 0) return '{status: ffra_pkg::ST_NOTALLOC, granted_offset: '0};
    for (int j = k; j + 1 < an; j++) ao[j] = ao[j + 1];
    an--;
    for (int j = 0; j < an; j++) rg_rank[ao[j]] = j;
    size = rg_len[m];
    fin = addr + size;
    rg_kind[m] = ffra_pkg::KIND_FREE;
    if (un == 0) begin
      uo[0] = m;
      un = 1;
    end else begin
      p = un;
      for (int j = un - 1; j >= 0; j--) if (addr < rg_start[uo[j]]) p = j;
      pr = (p > 0) ? uo[p - 1] : -1;
      nx = (p < un) ? uo[p] : -1;
      a = (pr >= 0) && (rg_start[pr] + rg_len[pr] == addr);
      b = (nx >= 0) && (fin == rg_start[nx]);
      if (a && b) begin
        rg_len[pr] = rg_len[pr] + size + rg_len[nx];
        for (int j = p; j + 1 < un; j++) uo[j] = uo[j + 1];
        un--;
        make_spare(nx);
        make_spare(m);
      end else if (a) begin
        rg_len[pr] = rg_len[pr] + size;
        make_spare(m);
      end else if (b) begin
        rg_start[nx] = addr;
        rg_len[nx] = rg_len[nx] + size;
        make_spare(m);
      end else begin
        for (int j = un; j > p; j--) uo[j] = uo[j - 1];
        uo[p] = m;
        un++;
      end
    end
    for (int j = 0; j < un; j++) rg_rank[uo[j]] = j;
    return '{status: ffra_pkg::ST_OK, granted_offset: '0};
  endfunction

  task automatic idle_gap();
    if (gaps_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 19)) @(posedge clk);
  endtask

  // Issue one request, wait for acceptance, record the predicted response.
  task automatic send_request(input logic op, input logic [31:0] size,
                              input logic [31:0] offs);
    ffra_pkg::in_req_t req;
    req.opcode = op;
    req.request_size = size;
    req.block_offset = offs;
    idle_gap();
    start <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    if (op == ffra_pkg::OP_ALLOC) pending_rsp.push_back(predict_alloc(size));
    else pending_rsp.push_back(predict_free(offs));
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Drain responses, let a trailing failed request finish, then write pool_size.
  task automatic write_pool(input logic [31:0] value);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (3 * ND + 8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_bytes = value;
    pool_restart();
  endtask

  function automatic logic [31:0] pick_live_offset();
    int idx [$];
    for (int i = 0; i < ND; i++) if (rg_kind[i] == ffra_pkg::KIND_USED) idx.push_back(i);
    if (idx.size() == 0 || $urandom_range(0, 7) == 0) return $urandom;
    return rg_start[idx[$urandom_range(0, idx.size() - 1)]];
  endfunction

  function automatic logic [31:0] pick_free_len();
    int idx [$];
    for (int i = 0; i < ND; i++) if (rg_kind[i] == ffra_pkg::KIND_FREE) idx.push_back(i);
    if (idx.size() == 0) return $urandom_range(0, 64);
    return rg_len[idx[$urandom_range(0, idx.size() - 1)]];
  endfunction

  // Extreme sizes, exact fit, running out of spares, free merges both ways.
  task automatic test_directed();
    write_pool(32'd1000);
    send_request(ffra_pkg::OP_ALLOC, 32'd0, 0);          // zero-length split
    send_request(ffra_pkg::OP_ALLOC, 32'hFFFF_FFFF, 0);  // no fit
    send_request(ffra_pkg::OP_ALLOC, 32'd100, 0);
    send_request(ffra_pkg::OP_ALLOC, 32'd200, 0);
    send_request(ffra_pkg::OP_ALLOC, 32'd300, 0);
    send_request(ffra_pkg::OP_FREE, 0, 32'd100);         // no neighbor free
    send_request(ffra_pkg::OP_FREE, 0, 32'd300);         // merge with both neighbors
    send_request(ffra_pkg::OP_FREE, 0, 32'd0);           // oldest at zero (zero-length)
    send_request(ffra_pkg::OP_FREE, 0, 32'hFFFF_FFFF);   // not allocated
    send_request(ffra_pkg::OP_ALLOC, 32'd400, 0);
    for (int i = 0; i < 7; i++) send_request(ffra_pkg::OP_ALLOC, 32'd10, 0); // exhaust spares
    send_request(ffra_pkg::OP_ALLOC, 32'd900, 0);
    write_pool(32'd64);
    send_request(ffra_pkg::OP_ALLOC, 32'd64, 0);          // exact fit, list empty
    send_request(ffra_pkg::OP_ALLOC, 32'd1, 0);           // nothing unallocated
    send_request(ffra_pkg::OP_FREE, 0, 32'd0);            // free into empty list
    write_pool(32'hFFFF_FFFF);
    send_request(ffra_pkg::OP_ALLOC, 32'hFFFF_FFFE, 0);
    send_request(ffra_pkg::OP_ALLOC, 32'd1, 0);
    send_request(ffra_pkg::OP_FREE, 0, 32'd0);
    write_pool(32'd0);
    send_request(ffra_pkg::OP_ALLOC, 32'd0, 0);
  endtask

  // Mostly sensible alloc/free traffic with random content and some noise.
  task automatic test_random(input int count, input logic [31:0] pool);
    logic [31:0] sz;
    write_pool(pool);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1)) begin
        send_request(ffra_pkg::OP_FREE, $urandom, pick_live_offset());
      end else begin
        case ($urandom_range(0, 5))
          0: sz = pick_free_len();
          1: sz = $urandom;
          2: sz = $urandom_range(0, 3);
          default: sz = $urandom_range(0, (pool >> 3) + 1);
        endcase
        send_request(ffra_pkg::OP_ALLOC, sz, $urandom);
      end
    end
  endtask

  initial begin
    pool_bytes = ffra_pkg::POOL_RESET;
    pool_restart();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(600, ffra_pkg::POOL_RESET);
    test_random(400, 32'd200);
    test_random(400, 32'hFFFF_FFFF);
    test_random(300, $urandom);
    gaps_on = 1'b0;
    test_random(300, 32'd4096);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (3 * ND + 8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
